### rtl/min_queue_two_stack_unit_defines.svh
// Assertion macros shared by the checker of the two-stack minimum queue.
`ifndef MIN_QUEUE_TWO_STACK_UNIT_DEFINES_SVH
`define MIN_QUEUE_TWO_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock and held off during reset.
`define MQTS_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("min queue check failed");

// Next-cycle implication, sampled on clock and held off during reset.
`define MQTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("min queue check failed");

`endif

### rtl/mqts_pkg.sv
// Shared constants, types and the signed minimum function of the two-stack minimum queue.
package mqts_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 1024;
   localparam int WORD_W = 32;
   localparam int MODE_W = 2;
   localparam int STATUS_W = 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes carried in req_tuser
   localparam mode_type MODE_ENQ = 2'd0;
   localparam mode_type MODE_DEQ = 2'd1;
   localparam mode_type MODE_CLR = 2'd2;
   localparam mode_type MODE_PEEK = 2'd3;

   // Status codes carried in rsp_tuser
   localparam status_type ST_OK = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   // Signed minimum of two words
   function automatic word_type smin(input word_type a, input word_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

### rtl/min_queue_two_stack_unit.sv
// Two-stack FIFO of signed words that reports the minimum of all held values.
//
// Usage: each operation arrives as one transfer on the req_ channel (req_tuser holds
// the operation: enqueue, dequeue, clear or peek; req_tdata the value to enqueue) and
// gives exactly one transfer on the rsp_ channel with the front or dequeued value,
// the minimum held, the count held and a status in rsp_tuser.
// The block handles one operation at a time; req_tready is low while it works.
// Enqueue, clear, peek and a dequeue that empties the output stack pass through
// the execute and finish steps to the result in the output register; a dequeue
// that exposes a new output-stack top also passes a load step for the memory
// read. When the output stack is empty a dequeue or peek first moves the input
// stack over, one entry per cycle through the shared compare unit; each entry
// moves only once. The block returns to idle when the result is registered and
// then takes the next operation. The result sits in an output register; the next
// operation is taken while it waits. If the receiver stalls, the following result
// is held in the finish step until the register frees, and no new operation is
// accepted meanwhile.
// Reset (synchronous, active high) empties both stacks at once; no clearing pass.
module min_queue_two_stack_unit
   import mqts_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((2 * WORD_W + CNT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // [31:0] value_in
   input  logic [1:0]       req_tuser,   // [1:0] mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [31:0] value_out, [63:32] minimum, count, zero pad
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MOVE = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] in_h_ff, in_h_in;
   logic [CNT_W-1:0] out_h_ff, out_h_in;
   mode_type         mode_ff, mode_in;
   word_type         value_ff, value_in;
   word_type         in_min_ff, in_min_in;
   word_type         top_val_ff, top_val_in;
   word_type         top_min_ff, top_min_in;
   word_type         res_val_ff, res_val_in;
   status_type       res_st_ff, res_st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_val_ff, rsp_val_in;
   word_type         rsp_min_ff, rsp_min_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   status_type       rsp_st_ff, rsp_st_in;

   // Stack memories: input stack keeps values only, output stack keeps value and minimum
   word_type                 in_mem [QUEUE_DEPTH];
   logic [2*WORD_W-1:0]      out_mem [QUEUE_DEPTH];
   word_type                 in_rd_ff;
   logic [2*WORD_W-1:0]      out_rd_ff;
   logic                     in_we, out_we;
   logic [ADDR_W-1:0]        in_rd_addr, out_rd_addr;
   logic [CNT_W-1:0]         in_rd_idx, out_rd_idx;

   // Shared compare unit
   word_type   cmp_a, cmp_b, cmp_min;
   logic [CNT_W-1:0] total;
   logic       accept, rsp_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign total      = in_h_ff + out_h_ff;

   // Read addresses: next input-stack entry to move, and the entry below the output top
   assign in_rd_idx   = in_h_ff - ((state_ff == S_MOVE) ? CNT_W'(2) : CNT_W'(1));
   assign in_rd_addr  = in_rd_idx[ADDR_W-1:0];
   assign out_rd_idx  = out_h_ff - CNT_W'(2);
   assign out_rd_addr = out_rd_idx[ADDR_W-1:0];

   // Steer the compare unit by sequencer step
   always_comb begin
      unique case (state_ff)
         S_EXEC: begin
            cmp_a = value_ff;
            cmp_b = in_min_ff;
         end
         S_MOVE: begin
            cmp_a = in_rd_ff;
            cmp_b = top_min_ff;
         end
         default: begin
            cmp_a = in_min_ff;
            cmp_b = top_min_ff;
         end
      endcase
      cmp_min = smin(cmp_a, cmp_b);
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      in_h_in      = in_h_ff;
      out_h_in     = out_h_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      in_min_in    = in_min_ff;
      top_val_in   = top_val_ff;
      top_min_in   = top_min_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      in_we        = 1'b0;
      out_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Latch the operation
            if (accept) begin
               mode_in  = req_tuser;
               value_in = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_val_in = '0;
            res_st_in  = ST_OK;
            state_in   = S_DONE;
            case (mode_ff) inside
               MODE_ENQ: begin
                  if (total == CNT_W'(QUEUE_DEPTH)) begin
                     res_st_in = ST_FULL;
                  end else begin
                     in_we     = 1'b1;
                     in_min_in = (in_h_ff == '0) ? value_ff : cmp_min;
                     in_h_in   = in_h_ff + CNT_W'(1);
                  end
               end
               MODE_CLR: begin
                  in_h_in  = '0;
                  out_h_in = '0;
               end
               MODE_DEQ, MODE_PEEK: begin
                  if (total == '0) begin
                     res_st_in = ST_EMPTY;
                  end else if (out_h_ff == '0) begin
                     // Output stack empty: move the input stack over first
                     state_in = S_MOVE;
                  end else begin
                     res_val_in = top_val_ff;
                     if (mode_ff == MODE_DEQ) begin
                        out_h_in = out_h_ff - CNT_W'(1);
                        if (out_h_ff > CNT_W'(1)) begin
                           state_in = S_LOAD;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         S_MOVE: begin
            // Push one moved value onto the output stack
            out_we     = 1'b1;
            top_val_in = in_rd_ff;
            top_min_in = (out_h_ff == '0) ? in_rd_ff : cmp_min;
            out_h_in   = out_h_ff + CNT_W'(1);
            in_h_in    = in_h_ff - CNT_W'(1);
            if (in_h_ff == CNT_W'(1)) begin
               state_in = S_EXEC;
            end
         end
         S_LOAD: begin
            // Take the new output-stack top from memory
            top_val_in = out_rd_ff[WORD_W-1:0];
            top_min_in = out_rd_ff[2*WORD_W-1:WORD_W];
            state_in   = S_DONE;
         end
         S_DONE: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               rsp_cnt_in   = total;
               if (in_h_ff == '0 && out_h_ff == '0) begin
                  rsp_min_in = '0;
               end else if (in_h_ff == '0) begin
                  rsp_min_in = top_min_ff;
               end else if (out_h_ff == '0) begin
                  rsp_min_in = in_min_ff;
               end else begin
                  rsp_min_in = cmp_min;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_h_ff      <= '0;
         out_h_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_h_ff      <= in_h_in;
         out_h_ff     <= out_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      value_ff   <= value_in;
      in_min_ff  <= in_min_in;
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_min_ff <= rsp_min_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // Input stack memory
   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_h_ff[ADDR_W-1:0]] <= value_ff;
      end
      in_rd_ff <= in_mem[in_rd_addr];
   end

   // Output stack memory
   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_h_ff[ADDR_W-1:0]] <= {top_min_in, top_val_in};
      end
      out_rd_ff <= out_mem[out_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_cnt_ff, rsp_min_ff, rsp_val_ff});
   assign rsp_tuser  = rsp_st_ff;

endmodule

### rtl/mqts_checker.sv
// Port-level checker for the two-stack minimum queue, bound to the top level.
`include "min_queue_two_stack_unit_defines.svh"

module mqts_checker
   import mqts_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((2 * WORD_W + CNT_W + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [31:0]      req_tdata,   // [31:0] value_in
   input logic [1:0]       req_tuser,   // [1:0] mode
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,   // [31:0] value_out, [63:32] minimum, count, zero pad
   input logic [1:0]       rsp_tuser    // [1:0] status
);

   logic [CNT_W-1:0] rsp_count;

   assign rsp_count = rsp_tdata[2*WORD_W +: CNT_W];

   // A stalled result holds
   `MQTS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // One operation at a time: ready drops after each accepted transfer
   `MQTS_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready && !$isunknown(req_tuser), !req_tready)

   // Status is always a defined code
   `MQTS_ASSERT_IMPLY(a_status_code, rsp_tvalid, rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY || rsp_tuser == ST_FULL)

   // An empty-queue error reports no value, no minimum and no count
   `MQTS_ASSERT_IMPLY(a_empty_zero, rsp_tvalid && rsp_tuser == ST_EMPTY, rsp_tdata == '0)

   // Count never exceeds the store
   `MQTS_ASSERT_IMPLY(a_count_range, rsp_tvalid, rsp_count <= CNT_W'(QUEUE_DEPTH))

   logic unused_ok;
   assign unused_ok = ^req_tdata;

endmodule

bind min_queue_two_stack_unit mqts_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mqts_checker (.*);
